### src/slsu_pkg.sv
// Shared types, constants and helper functions for the sequential list unit.
// Used by slsu_cell, the top level and the checker; depends on nothing else.
package slsu_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int OP_W     = 2;
   localparam int POS_W    = 7;
   localparam int STAT_W   = 2;
   localparam int FPOS_W   = 6;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STAT_W-1:0] ST_REJECT   = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_EXEC = 2'b10
   } fsm_type;

   // Per-cycle control broadcast to every cell of the row.
   typedef struct packed {
      logic capture;     // compare the incoming key and latch the match flag
      logic shift_up;    // insert: open a gap at the boundary and load the key
      logic shift_down;  // delete: close the gap at the boundary
   } cell_ctrl_type;

   // Priority encoder: index of the lowest set bit, zero when none is set.
   function automatic logic [IDX_W-1:0] first_index(input logic [CAPACITY-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

### src/slsu_cell.sv
// One storage cell of the list row: holds one key and its match flag.
// Depends on slsu_pkg for widths and the control struct.
module slsu_cell (
   input  logic                          clock,
   input  slsu_pkg::cell_ctrl_type       ctrl,
   input  logic [slsu_pkg::IDX_W-1:0]    cell_index,
   input  logic [slsu_pkg::CNT_W-1:0]    count,
   input  logic [slsu_pkg::IDX_W-1:0]    boundary,
   input  logic [slsu_pkg::KEY_W-1:0]    cmp_key,
   input  logic [slsu_pkg::KEY_W-1:0]    load_key,
   input  logic [slsu_pkg::KEY_W-1:0]    left_value,
   input  logic [slsu_pkg::KEY_W-1:0]    right_value,
   output logic [slsu_pkg::KEY_W-1:0]    value,
   output logic                          match
);

   logic [slsu_pkg::KEY_W-1:0] value_ff, value_in;
   logic                       match_ff, match_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.shift_up) begin
         if (cell_index > boundary) begin
            value_in = left_value;
         end else if (cell_index == boundary) begin
            value_in = load_key;
         end
      end else if (ctrl.shift_down) begin
         if (cell_index >= boundary) begin
            value_in = right_value;
         end
      end
   end

   // Only cells below the fill count take part in a search.
   assign match_in = ctrl.capture
                     ? ((slsu_pkg::CNT_W'(cell_index) < count) && (value_ff == cmp_key))
                     : match_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign value = value_ff;
   assign match = match_ff;

endmodule

### src/sequential_list_insert_delete_search_unit.sv
// A word taken in the idle state moves the unit to the execute state, and the
// result strobe is registered from it; busy is high only in the execute cycle,
// so the next word is taken while the previous result is on the rsp_ ports.
// The receiver cannot stall; rsp_strobe lasts exactly one cycle.
// Reset (synchronous, active high) empties the list and returns to idle; the
// key cells themselves are not cleared.
module sequential_list_insert_delete_search_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [slsu_pkg::OP_W-1:0]          req_opcode,
   input  logic signed [slsu_pkg::KEY_W-1:0]  req_key,
   input  logic [slsu_pkg::POS_W-1:0]         req_position,
   output logic                               rsp_strobe,
   output logic [slsu_pkg::STAT_W-1:0]        rsp_status,
   output logic [slsu_pkg::FPOS_W-1:0]        rsp_found_position,
   output logic [slsu_pkg::CNT_W-1:0]         rsp_entry_count
);

   // Control state.
   slsu_pkg::fsm_type             state_ff, state_in;
   logic [slsu_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                          strobe_ff, strobe_in;

   // Command held for the execute cycle.
   logic [slsu_pkg::OP_W-1:0]     op_ff;
   logic [slsu_pkg::KEY_W-1:0]    key_ff;
   logic [slsu_pkg::IDX_W-1:0]    pos_ff;
   logic                          reject_ff;

   // Result payload.
   logic [slsu_pkg::STAT_W-1:0]   status_ff, status_in;
   logic [slsu_pkg::FPOS_W-1:0]   fpos_ff, fpos_in;

   logic                          accept;
   logic                          exec;
   logic                          reject_now;
   logic                          found;
   logic [slsu_pkg::IDX_W-1:0]    first_idx;
   logic [slsu_pkg::IDX_W-1:0]    boundary;
   slsu_pkg::cell_ctrl_type       ctrl;
   logic [slsu_pkg::CAPACITY-1:0] match_vec;
   logic [slsu_pkg::KEY_W-1:0]    value_vec [slsu_pkg::CAPACITY];

   assign accept = start && !busy;
   assign exec   = (state_ff == slsu_pkg::FSM_EXEC);
   assign busy   = exec;

   // An insert is refused when its position lies past the end or the list is full.
   assign reject_now = (32'(req_position) > 32'(count_ff))
                    || (32'(count_ff) >= slsu_pkg::CAPACITY);

   // Every cell compares against the incoming key in the accept cycle, so the
   // match flags are ready for the execute cycle.
   assign found     = |match_vec;
   assign first_idx = slsu_pkg::first_index(match_vec);
   assign boundary  = (op_ff == slsu_pkg::OP_INSERT) ? pos_ff : first_idx;

   always_comb begin
      ctrl.capture    = accept;
      ctrl.shift_up   = exec && (op_ff == slsu_pkg::OP_INSERT) && !reject_ff;
      ctrl.shift_down = exec && (op_ff == slsu_pkg::OP_DELETE) && found;
   end

   // Row of cells; on a shift, cells past the boundary take a neighbor's key.
   for (genvar g = 0; g < slsu_pkg::CAPACITY; g++) begin : g_cell
      logic [slsu_pkg::KEY_W-1:0] left_v, right_v;
      if (g == 0) begin : g_first
         assign left_v = value_vec[g];
      end else begin : g_left
         assign left_v = value_vec[g-1];
      end
      if (g == slsu_pkg::CAPACITY - 1) begin : g_last
         assign right_v = value_vec[g];
      end else begin : g_right
         assign right_v = value_vec[g+1];
      end
      slsu_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_index  (slsu_pkg::IDX_W'(g)),
         .count       (count_ff),
         .boundary    (boundary),
         .cmp_key     ($unsigned(req_key)),
         .load_key    (key_ff),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (value_vec[g]),
         .match       (match_vec[g])
      );
   end

   // Execute cycle: decide status, position and the new count.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      fpos_in   = fpos_ff;
      case (state_ff)
         slsu_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = slsu_pkg::FSM_EXEC;
            end
         end
         slsu_pkg::FSM_EXEC: begin
            state_in  = slsu_pkg::FSM_IDLE;
            strobe_in = 1'b1;
            status_in = slsu_pkg::ST_DONE;
            fpos_in   = '0;
            case (op_ff)
               slsu_pkg::OP_INSERT: begin
                  if (reject_ff) begin
                     status_in = slsu_pkg::ST_REJECT;
                  end else begin
                     count_in = count_ff + slsu_pkg::CNT_W'(1);
                  end
               end
               slsu_pkg::OP_DELETE: begin
                  if (found) begin
                     count_in = count_ff - slsu_pkg::CNT_W'(1);
                     fpos_in  = slsu_pkg::FPOS_W'(first_idx);
                  end else begin
                     status_in = slsu_pkg::ST_NOTFOUND;
                  end
               end
               slsu_pkg::OP_SEARCH: begin
                  if (found) begin
                     fpos_in = slsu_pkg::FPOS_W'(first_idx);
                  end else begin
                     status_in = slsu_pkg::ST_NOTFOUND;
                  end
               end
               default: begin
                  // Clear only drops the fill count; the cells keep their keys.
                  count_in = '0;
               end
            endcase
         end
         default: begin
            state_in = slsu_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= slsu_pkg::FSM_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_opcode;
         key_ff    <= $unsigned(req_key);
         pos_ff    <= slsu_pkg::IDX_W'(req_position);
         reject_ff <= reject_now;
      end
      status_ff <= status_in;
      fpos_ff   <= fpos_in;
   end

   // The count register already holds the post-operation value in the strobe cycle.
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_entry_count    = count_ff;

endmodule

### src/slsu_checker.sv
// Port-level checker for the sequential list unit, bound to the top level.
// Depends on slsu_pkg for widths and status codes.
module slsu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_strobe,
   input logic [slsu_pkg::STAT_W-1:0]        rsp_status,
   input logic [slsu_pkg::FPOS_W-1:0]        rsp_found_position,
   input logic [slsu_pkg::CNT_W-1:0]         rsp_entry_count
);

   // Every accepted word yields its result strobe.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("result strobe missing two cycles after accept");

   // A result only follows a busy cycle.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result strobe without a preceding operation");

   // A missed key or a rejected insert reports position zero.
   a_fpos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == slsu_pkg::ST_NOTFOUND
                   || rsp_status == slsu_pkg::ST_REJECT)) |-> (rsp_found_position == '0))
      else $error("nonzero position on a failed operation");

   // A rejected insert leaves the count unchanged.
   a_reject_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == slsu_pkg::ST_REJECT) |-> $stable(rsp_entry_count))
      else $error("count changed on a rejected insert");

   // The count never exceeds the capacity.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(rsp_entry_count) <= slsu_pkg::CAPACITY)
      else $error("entry count above capacity");

endmodule

bind sequential_list_insert_delete_search_unit slsu_checker u_slsu_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_status         (rsp_status),
   .rsp_found_position (rsp_found_position),
   .rsp_entry_count    (rsp_entry_count)
);

### verif/tb_sequential_list_insert_delete_search_unit.sv
// Self-checking testbench for the sequential list unit: ordered inserts, deletes,
// searches and clears against a behavioral list kept alongside the block.
// Depends on slsu_pkg and sequential_list_insert_delete_search_unit only.
`timescale 1ns / 1ps

module tb_sequential_list_insert_delete_search_unit;
   import slsu_pkg::*;

   // One command word as it travels on the req_ ports.
   typedef struct {
      logic [OP_W-1:0]         opcode;
      logic signed [KEY_W-1:0] key;
      logic [POS_W-1:0]        position;
   } list_word_t;

   // One reply word as it appears on the rsp_ ports.
   typedef struct {
      logic [STAT_W-1:0] status;
      logic [FPOS_W-1:0] found_position;
      logic [CNT_W-1:0]  entry_count;
   } list_reply_t;

   // Flavors of random traffic. Growing and shrinking runs push the list to
   // its full and empty ends; noise throws arbitrary words at it.
   typedef enum int {
      EP_GROW,
      EP_SHRINK,
      EP_MIXED,
      EP_NOISE
   } episode_e;

   localparam int RANDOM_WORDS = 800;
   localparam int BLOCK_WORDS  = 100;
   localparam int POOL_SIZE    = 12;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [OP_W-1:0]         req_opcode = '0;
   logic signed [KEY_W-1:0] req_key = '0;
   logic [POS_W-1:0]        req_position = '0;
   logic                    rsp_strobe;
   logic [STAT_W-1:0]       rsp_status;
   logic [FPOS_W-1:0]       rsp_found_position;
   logic [CNT_W-1:0]        rsp_entry_count;

   // Words waiting to be sent; the head stays here until the block takes it.
   list_word_t  ops_queued[$];
   // Replies the list predicts, oldest first.
   list_reply_t replies_due[$];

   // Shadow of the list contents, updated as each word is accepted.
   logic signed [KEY_W-1:0] list_keys[CAPACITY];
   int                      list_count = 0;

   // Chance in percent that the sender leaves a cycle idle.
   int sender_idle_pct = 0;

   int error_count   = 0;
   int replies_seen  = 0;
   int n_insert      = 0;
   int n_reject      = 0;
   int n_full_reject = 0;
   int n_delete      = 0;
   int n_search      = 0;
   int n_clear       = 0;
   int n_found       = 0;
   int n_missed      = 0;
   int peak_count    = 0;

   logic signed [KEY_W-1:0] key_pool[POOL_SIZE];

   sequential_list_insert_delete_search_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_key            (req_key),
      .req_position       (req_position),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count)
   );

   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   // Reset is asserted from time zero, released once and never raised again.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard stop in case the block hangs or stops answering.
   initial begin
      #2_000_000;
      $display("sequential_list_insert_delete_search_unit verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at reply %0d: %s", replies_seen, what);
      error_count++;
   endtask

   // Applies one accepted word to the shadow list and works out the reply the
   // block must give. Keys match on all 32 bits; the first match wins.
   task automatic apply_list_op(input list_word_t w, output list_reply_t r);
      int hit;
      r.status         = ST_DONE;
      r.found_position = '0;
      hit              = -1;
      case (w.opcode)
         OP_INSERT: begin
            n_insert++;
            if (int'(w.position) > list_count || list_count >= CAPACITY) begin
               r.status = ST_REJECT;
               n_reject++;
               if (list_count >= CAPACITY) begin
                  n_full_reject++;
               end
            end else begin
               for (int i = list_count; i > int'(w.position); i--) begin
                  list_keys[i] = list_keys[i-1];
               end
               list_keys[w.position] = w.key;
               list_count++;
            end
         end
         OP_DELETE, OP_SEARCH: begin
            if (w.opcode == OP_DELETE) begin
               n_delete++;
            end else begin
               n_search++;
            end
            for (int i = 0; i < list_count && hit < 0; i++) begin
               if (list_keys[i] === w.key) begin
                  hit = i;
               end
            end
            if (hit < 0) begin
               r.status = ST_NOTFOUND;
               n_missed++;
            end else begin
               r.found_position = FPOS_W'(hit);
               n_found++;
               if (w.opcode == OP_DELETE) begin
                  for (int i = hit; i + 1 < list_count; i++) begin
                     list_keys[i] = list_keys[i+1];
                  end
                  list_count--;
               end
            end
         end
         default: begin
            // Clear only drops the count; the cells keep their old keys.
            n_clear++;
            list_count = 0;
         end
      endcase
      if (list_count > peak_count) begin
         peak_count = list_count;
      end
      r.entry_count = CNT_W'(list_count);
   endtask

   // Driver. At each edge it first notes whether the word on the ports was
   // taken (start high, busy low), then either keeps holding it, offers the
   // next queued word, or idles. The start line gets a single assignment per
   // edge so that a back-to-back word never sees start dip.
   always @(posedge clock) begin : drive_words
      logic        offer;
      list_reply_t due;
      if (reset) begin
         start <= 1'b0;
      end else begin
         offer = 1'b1;
         if (start && !busy) begin
            apply_list_op(ops_queued[0], due);
            replies_due.push_back(due);
            void'(ops_queued.pop_front());
         end else if (start) begin
            // Not taken yet: the word must stay on the ports unchanged.
            offer = 1'b0;
         end
         if (offer) begin
            if (ops_queued.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               start        <= 1'b1;
               req_opcode   <= ops_queued[0].opcode;
               req_key      <= ops_queued[0].key;
               req_position <= ops_queued[0].position;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. A strobed reply is taken at the edge that ends its cycle and is
   // compared field by field with the oldest prediction.
   always @(posedge clock) begin : check_replies
      list_reply_t want;
      if (!reset && rsp_strobe) begin
         replies_seen++;
         if (replies_due.size() == 0) begin
            report_mismatch($sformatf("reply with nothing outstanding (status %0d count %0d)",
                                      rsp_status, rsp_entry_count));
         end else begin
            want = replies_due.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, want.status));
            end
            if (rsp_found_position !== want.found_position) begin
               report_mismatch($sformatf("found_position %0d, expected %0d",
                                         rsp_found_position, want.found_position));
            end
            if (rsp_entry_count !== want.entry_count) begin
               report_mismatch($sformatf("entry_count %0d, expected %0d",
                                         rsp_entry_count, want.entry_count));
            end
         end
      end
   end

   task automatic queue_word(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] k,
                             input logic [POS_W-1:0] p);
      list_word_t w;
      w.opcode   = op;
      w.key      = k;
      w.position = p;
      ops_queued.push_back(w);
   endtask

   // Holds the sender back until every queued word is taken and every reply
   // has come home. Each reply follows its word, so nothing is left in flight.
   task automatic drain_list_ops();
      while (ops_queued.size() != 0 || replies_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Key to look up or delete: mostly one that is in the list, so that hits
   // are common, sometimes a pool key (duplicates, stale keys) or a random one.
   function automatic logic signed [KEY_W-1:0] pick_lookup_key();
      int r;
      r = $urandom_range(99);
      if (list_count > 0 && r < 75) begin
         return list_keys[$urandom_range(list_count - 1, 0)];
      end else if (r < 90) begin
         return key_pool[$urandom_range(POOL_SIZE - 1, 0)];
      end
      return $urandom;
   endfunction

   // Builds one random word. The list state it reads may lag the block by the
   // couple of words still queued, which only blurs the aim a little.
   function automatic list_word_t random_word(input episode_e ep);
      list_word_t w;
      int         r;
      int         op_pick;
      op_pick = $urandom_range(99);
      case (ep)
         EP_GROW:   w.opcode = (op_pick < 85) ? OP_INSERT :
                               (op_pick < 90) ? OP_DELETE : OP_SEARCH;
         EP_SHRINK: w.opcode = (op_pick < 70) ? OP_DELETE :
                               (op_pick < 90) ? OP_SEARCH : OP_INSERT;
         EP_MIXED:  w.opcode = (op_pick < 40) ? OP_INSERT :
                               (op_pick < 65) ? OP_DELETE :
                               (op_pick < 97) ? OP_SEARCH : OP_CLEAR;
         default:   w.opcode = OP_W'($urandom);
      endcase
      if (ep == EP_NOISE) begin
         w.key      = $urandom;
         w.position = POS_W'($urandom);
         return w;
      end
      if (w.opcode == OP_INSERT) begin
         w.key = ($urandom_range(99) < 60) ? key_pool[$urandom_range(POOL_SIZE - 1, 0)]
                                           : $urandom;
      end else begin
         w.key = pick_lookup_key();
      end
      // Position: front, end of list, anywhere inside, or anything the field holds.
      r = $urandom_range(99);
      if (r < 30) begin
         w.position = '0;
      end else if (r < 55) begin
         w.position = POS_W'(list_count);
      end else if (r < 85) begin
         w.position = POS_W'($urandom_range(list_count, 0));
      end else begin
         w.position = POS_W'($urandom);
      end
      return w;
   endfunction

   // Stimulus: a directed pass over the special cases, then blocks of random
   // words under changing idle rates, with a full drain between blocks.
   initial begin : stimulus
      int       block_idx;
      int       made;
      int       ep_left;
      episode_e ep;
      int       idle_plan[8];

      idle_plan = '{0, 77, 0, 30, 77, 0, 30, 77};
      key_pool[0] = 32'sh7FFF_FFFF;
      key_pool[1] = 32'sh8000_0000;
      key_pool[2] = '0;
      key_pool[3] = -32'sd1;
      for (int i = 4; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
      end

      wait (!reset);
      @(negedge clock);

      // Directed pass, back to back.
      sender_idle_pct = 0;
      queue_word(OP_SEARCH, '0, '0);               // search on an empty list
      queue_word(OP_DELETE, 32'sd5, '0);           // delete on an empty list
      queue_word(OP_INSERT, 32'sd9, 7'd1);         // position past the end
      queue_word(OP_INSERT, 32'sd9, 7'd127);       // largest position the field holds
      queue_word(OP_INSERT, 32'sh7FFF_FFFF, 7'd0); // into an empty list
      queue_word(OP_INSERT, 32'sh8000_0000, 7'd1); // append at the end
      queue_word(OP_INSERT, -32'sd1, 7'd0);        // at the front
      queue_word(OP_INSERT, '0, 7'd1);             // in the middle
      queue_word(OP_INSERT, -32'sd1, 7'd4);        // duplicate appended at the end
      queue_word(OP_INSERT, 32'sd3, 7'd6);         // one past the end
      queue_word(OP_SEARCH, -32'sd1, '0);          // first of two matches
      queue_word(OP_SEARCH, 32'sh8000_0000, '0);
      queue_word(OP_DELETE, -32'sd1, '0);          // removes only the first match
      queue_word(OP_SEARCH, -32'sd1, '0);          // the later copy moved down
      queue_word(OP_DELETE, 32'sh7FFF_FFFF, '0);
      queue_word(OP_SEARCH, 32'sd12345, '0);       // no match
      queue_word(OP_DELETE, 32'sd12345, 7'd127);   // no match, position ignored
      queue_word(OP_SEARCH, '0, 7'd64);
      queue_word(OP_CLEAR, 32'sh5A5A_A5A5, 7'd33);
      queue_word(OP_SEARCH, '0, '0);               // old cell contents no longer count
      queue_word(OP_DELETE, 32'sh8000_0000, '0);
      queue_word(OP_INSERT, 32'sd1, 7'd64);        // past the end of an empty list
      queue_word(OP_INSERT, 32'sd1, 7'd0);
      queue_word(OP_CLEAR, '0, '0);
      drain_list_ops();

      // Random blocks. Each block runs at one idle rate and ends with the
      // sender paused until every reply is in.
      for (block_idx = 0; block_idx < RANDOM_WORDS / BLOCK_WORDS; block_idx++) begin
         sender_idle_pct = idle_plan[block_idx];
         made    = 0;
         ep_left = 0;
         ep      = EP_GROW;
         while (made < BLOCK_WORDS) begin
            if (ep_left == 0) begin
               if (block_idx == 0 && made == 0) begin
                  // Open with a long growing run so the list fills up early.
                  ep      = EP_GROW;
                  ep_left = 85;
               end else begin
                  case ($urandom_range(9))
                     0, 1, 2: ep = EP_GROW;
                     3, 4, 5: ep = EP_SHRINK;
                     6, 7, 8: ep = EP_MIXED;
                     default: ep = EP_NOISE;
                  endcase
                  ep_left = $urandom_range(60, 15);
               end
            end
            // Keep only a couple of words queued so that the aim of each new
            // word follows the list closely.
            while (ops_queued.size() >= 2) begin
               @(negedge clock);
            end
            ops_queued.push_back(random_word(ep));
            made++;
            ep_left--;
         end
         drain_list_ops();
      end

      // Everything has been answered; watch for a stray strobe before the final check.
      repeat (8) @(posedge clock);
      if (replies_due.size() != 0) begin
         report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
      end

      $display("Run covered %0d words: %0d inserts (%0d rejected, %0d on a full list), %0d deletes, %0d searches, %0d clears.",
               replies_seen, n_insert, n_reject, n_full_reject, n_delete, n_search, n_clear);
      $display("Lookups hit %0d times and missed %0d times; the list held at most %0d keys.",
               n_found, n_missed, peak_count);
      if (error_count == 0) begin
         $display("sequential_list_insert_delete_search_unit verification clean");
      end else begin
         $display("sequential_list_insert_delete_search_unit verification failed");
      end
      $finish;
   end

endmodule

### files.f
src/slsu_pkg.sv
src/slsu_cell.sv
src/sequential_list_insert_delete_search_unit.sv
src/slsu_checker.sv
verif/tb_sequential_list_insert_delete_search_unit.sv
